// ===== rtl/ssmv_pkg.sv =====
// Shared constants, types and codes for the symmetric sparse mat-vec accumulator.
`timescale 1ns / 1ps

package ssmv_pkg;

	// Vector storage
	localparam int VECTOR_LENGTH = 1024;
	localparam int IDX_W         = 10;
	localparam int ADDR_W        = $clog2(VECTOR_LENGTH);

	// Fixed-point widths: x and matrix values Q16.16, y Q32.16
	localparam int X_W    = 32;
	localparam int Y_W    = 48;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * X_W;
	// y memory word: saturation flag on top of the y value
	localparam int YMEM_W = Y_W + 1;

	// Transaction modes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_ELEM = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// Saturation limits of the y accumulator
	localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
	localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

	// Controls from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic mul_en;     // capture a new product
		logic acc_sel_rd; // 1: add onto y memory read data, 0: onto held y row entry
	} mac_ctrl_t;

endpackage

// ===== rtl/ssmv_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
`timescale 1ns / 1ps

interface ssmv_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          mode;
	logic [ssmv_pkg::IDX_W-1:0]          row_index;
	logic [ssmv_pkg::IDX_W-1:0]          col_index;
	logic signed [ssmv_pkg::X_W-1:0]     element_value;
	logic signed [ssmv_pkg::X_W-1:0]     x_value;
	logic signed [ssmv_pkg::Y_W-1:0]     y_initial;

	modport source (
		output valid, mode, row_index, col_index, element_value, x_value, y_initial,
		input  ready
	);
	modport sink (
		input  valid, mode, row_index, col_index, element_value, x_value, y_initial,
		output ready
	);
endinterface

interface ssmv_rsp_if;
	logic                            valid;
	logic                            ready;
	logic signed [ssmv_pkg::Y_W-1:0] y_out;
	logic                            saturated;

	modport source (
		output valid, y_out, saturated,
		input  ready
	);
	modport sink (
		input  valid, y_out, saturated,
		output ready
	);
endinterface

// ===== rtl/ssmv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ssmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ssmv_mac.sv =====
// Shared multiplier and saturating 48-bit accumulator for y updates.
`timescale 1ns / 1ps

module ssmv_mac (
	input  logic                                clk,
	input  ssmv_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [ssmv_pkg::X_W-1:0]     elem_val,
	input  logic signed [ssmv_pkg::X_W-1:0]     x_op,
	input  logic [ssmv_pkg::YMEM_W-1:0]         y_held,
	input  logic [ssmv_pkg::YMEM_W-1:0]         y_rd,
	output logic [ssmv_pkg::YMEM_W-1:0]         y_new
);

	logic signed [ssmv_pkg::PROD_W-1:0] prod_s1;
	logic [ssmv_pkg::YMEM_W-1:0]        acc_word;
	logic signed [ssmv_pkg::Y_W-1:0]    term;
	logic signed [ssmv_pkg::Y_W:0]      sum_wide;
	logic                               ovf;
	logic signed [ssmv_pkg::Y_W-1:0]    sum_sat;

	// Product stage: full Q16.16 x Q16.16 product
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= elem_val * x_op;
		end
	end

	// Accumulate stage: floor shift to Q32.16, add, clamp, sticky flag
	always_comb begin
		acc_word = ctrl.acc_sel_rd ? y_rd : y_held;
		// |product| <= 2^62, so the shifted term fits the y width
		term     = prod_s1[ssmv_pkg::FRAC_W +: ssmv_pkg::Y_W];
		sum_wide = {acc_word[ssmv_pkg::Y_W-1], acc_word[ssmv_pkg::Y_W-1:0]}
		         + {term[ssmv_pkg::Y_W-1], term};
		ovf      = sum_wide[ssmv_pkg::Y_W] != sum_wide[ssmv_pkg::Y_W-1];
		if (!ovf) begin
			sum_sat = sum_wide[ssmv_pkg::Y_W-1:0];
		end else if (sum_wide[ssmv_pkg::Y_W]) begin
			sum_sat = ssmv_pkg::Y_MIN;
		end else begin
			sum_sat = ssmv_pkg::Y_MAX;
		end
		y_new = {acc_word[ssmv_pkg::Y_W] | ovf, sum_sat};
	end

endmodule

// ===== rtl/symmetric_sparse_matvec_accumulate.sv =====
// Top level: sequencer around the x and y memories and the shared MAC unit.
//
//  channel | dir | payload                                            | transaction
//  --------+-----+----------------------------------------------------+----------------
//  req     | in  | mode, row_index, col_index, element_value,         | valid & ready
//          |     | x_value, y_initial                                 |
//  rsp     | out | y_out, saturated                                   | valid & ready
//
// A vector load writes both memories on acceptance; a result read passes through READ;
// a matrix element passes MUL1, ADD1 and ADD2 (ADD2 skipped on the diagonal), doing two
// y read-modify-writes (one if diagonal) via one multiplier and one saturating adder.
// Reset clears the sequencer and the response valid; memories are not cleared. The
// saturation flag lives beside each y entry and is cleared when that entry is loaded.
// A read waits in its final state while the response register is still full.
`timescale 1ns / 1ps

module symmetric_sparse_matvec_accumulate (
	input  logic              clk,
	input  logic              arst_n,
	ssmv_req_if.sink          req,
	ssmv_rsp_if.source        rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_ADD1 = 3'd2;
	localparam logic [2:0] ST_ADD2 = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;

	logic [2:0]                          state_q;
	logic [ssmv_pkg::ADDR_W-1:0]         row_q;
	logic [ssmv_pkg::ADDR_W-1:0]         col_q;
	logic signed [ssmv_pkg::X_W-1:0]     val_q;
	logic                                diag_q;
	logic                                rd_ok_q;
	logic [ssmv_pkg::YMEM_W-1:0]         y_row_q;

	logic                                out_valid_q;
	logic signed [ssmv_pkg::Y_W-1:0]     y_out_q;
	logic                                sat_q;

	logic                                accept;
	logic                                row_ok;
	logic                                col_ok;
	logic [ssmv_pkg::ADDR_W-1:0]         req_row;
	logic [ssmv_pkg::ADDR_W-1:0]         req_col;
	logic                                out_free;

	logic                                x_we;
	logic [ssmv_pkg::ADDR_W-1:0]         x_waddr;
	logic [ssmv_pkg::X_W-1:0]            x_wdata;
	logic                                x_re;
	logic [ssmv_pkg::ADDR_W-1:0]         x_raddr;
	logic [ssmv_pkg::X_W-1:0]            x_rd;

	logic                                y_we;
	logic [ssmv_pkg::ADDR_W-1:0]         y_waddr;
	logic [ssmv_pkg::YMEM_W-1:0]         y_wdata;
	logic                                y_re;
	logic [ssmv_pkg::ADDR_W-1:0]         y_raddr;
	logic [ssmv_pkg::YMEM_W-1:0]         y_rd;

	ssmv_pkg::mac_ctrl_t                 mac_ctrl;
	logic [ssmv_pkg::YMEM_W-1:0]         y_new;

	// Request decode
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign row_ok    = int'(req.row_index) < ssmv_pkg::VECTOR_LENGTH;
	assign col_ok    = int'(req.col_index) < ssmv_pkg::VECTOR_LENGTH;
	assign req_row   = req.row_index[ssmv_pkg::ADDR_W-1:0];
	assign req_col   = req.col_index[ssmv_pkg::ADDR_W-1:0];
	assign out_free  = !out_valid_q || rsp.ready;

	// Memory port control
	always_comb begin
		x_we     = 1'b0;
		x_waddr  = req_row;
		x_wdata  = req.x_value;
		x_re     = 1'b0;
		x_raddr  = req_col;
		y_we     = 1'b0;
		y_waddr  = req_row;
		y_wdata  = {1'b0, req.y_initial};
		y_re     = 1'b0;
		y_raddr  = req_row;
		mac_ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.mode == ssmv_pkg::MODE_LOAD && row_ok) begin
					x_we = 1'b1;
					y_we = 1'b1;
				end
				if (accept && req.mode == ssmv_pkg::MODE_ELEM && row_ok && col_ok) begin
					x_re = 1'b1;
					y_re = 1'b1;
				end
				if (accept && req.mode == ssmv_pkg::MODE_READ && row_ok) begin
					y_re = 1'b1;
				end
			end
			ST_MUL1: begin
				// x[col] is here; fetch the mirrored operands
				mac_ctrl.mul_en = 1'b1;
				x_re            = !diag_q;
				x_raddr         = row_q;
				y_re            = !diag_q;
				y_raddr         = col_q;
			end
			ST_ADD1: begin
				// y[row] += val*x[col]; x[row] is here for the mirrored product
				mac_ctrl.mul_en     = !diag_q;
				mac_ctrl.acc_sel_rd = 1'b0;
				y_we                = 1'b1;
				y_waddr             = row_q;
				y_wdata             = y_new;
			end
			ST_ADD2: begin
				// y[col] += val*x[row]
				mac_ctrl.acc_sel_rd = 1'b1;
				y_we                = 1'b1;
				y_waddr             = col_q;
				y_wdata             = y_new;
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && req.mode == ssmv_pkg::MODE_ELEM && row_ok && col_ok) begin
						state_q <= ST_MUL1;
					end else if (accept && req.mode == ssmv_pkg::MODE_READ) begin
						state_q <= ST_READ;
					end
				end
				ST_MUL1: state_q <= ST_ADD1;
				ST_ADD1: state_q <= diag_q ? ST_IDLE : ST_ADD2;
				ST_ADD2: state_q <= ST_IDLE;
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Transaction fields held for the element and read sequences
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q   <= req_row;
			col_q   <= req_col;
			val_q   <= req.element_value;
			diag_q  <= req.row_index == req.col_index;
			rd_ok_q <= row_ok;
		end
		if (state_q == ST_MUL1) begin
			y_row_q <= y_rd;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_READ && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ && out_free) begin
			y_out_q <= rd_ok_q ? y_rd[ssmv_pkg::Y_W-1:0] : '0;
			sat_q   <= rd_ok_q && y_rd[ssmv_pkg::Y_W];
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.y_out     = y_out_q;
	assign rsp.saturated = sat_q;

	// Storage and arithmetic
	ssmv_ram #(
		.WIDTH (ssmv_pkg::X_W),
		.DEPTH (ssmv_pkg::VECTOR_LENGTH)
	) u_xmem (
		.clk   (clk),
		.we    (x_we),
		.waddr (x_waddr),
		.wdata (x_wdata),
		.re    (x_re),
		.raddr (x_raddr),
		.rdata (x_rd)
	);

	ssmv_ram #(
		.WIDTH (ssmv_pkg::YMEM_W),
		.DEPTH (ssmv_pkg::VECTOR_LENGTH)
	) u_ymem (
		.clk   (clk),
		.we    (y_we),
		.waddr (y_waddr),
		.wdata (y_wdata),
		.re    (y_re),
		.raddr (y_raddr),
		.rdata (y_rd)
	);

	ssmv_mac u_mac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.elem_val (val_q),
		.x_op     (x_rd),
		.y_held   (y_row_q),
		.y_rd     (y_rd),
		.y_new    (y_new)
	);

	// Checks
	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_READ)
		else $error("response raised outside a read");

	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(y_we && y_re) |-> y_waddr != y_raddr)
		else $error("y read and write hit the same entry");

	a_add2_off_diag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD2 |-> !diag_q)
		else $error("mirrored update on a diagonal element");

	// Mirrored y fetch happens only off the diagonal
	a_mul1_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL1 |=> state_q == ST_ADD1 && $past(y_re) == !diag_q)
		else $error("element sequence broken after first product");

endmodule
